// ----- hw/rtl/wodo_pkg.sv -----
// Shared types and constants for the wheel encoder odometry block.
// No dependencies; wodo_lane and the top level in hw/rtl refer to this package.
`default_nettype none

package wodo_pkg;

    // APB register map: register index = paddr[3:2]
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0]  REG_RAD_PER_TICK = 2'd0;
    localparam logic [1:0]  REG_WINDOW_US    = 2'd1;
    localparam logic [1:0]  REG_EMA_ALPHA    = 2'd2;

    localparam logic [31:0] RAD_PER_TICK_RST = 32'd6588397;
    localparam logic [19:0] WINDOW_US_RST    = 20'd40000;
    localparam logic [16:0] EMA_ALPHA_RST    = 17'd26214;

    // microseconds per second, scales the velocity numerator
    localparam logic [19:0] US_PER_SEC = 20'd1000000;
    // alpha of one in Q1.16
    localparam logic [16:0] ALPHA_ONE  = 17'h10000;

    typedef struct packed {
        logic [31:0] rad_per_tick;
        logic [19:0] window_us;
        logic [16:0] ema_alpha;
    } cfg_t;

    // per-item command handed to both wheel lanes
    typedef struct packed {
        logic start;
        logic seed;
        logic advance;
        logic sample;
    } lane_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wodo_in_if.sv -----
// Input channel of the odometry block: valid/ready plus one encoder beat.
// No dependencies.
`default_nettype none

interface wodo_in_if;
    logic               valid;
    logic               ready;
    logic               frame_valid;
    logic signed [31:0] left_enc;
    logic signed [31:0] right_enc;
    logic        [19:0] period_us;

    modport source (output valid, frame_valid, left_enc, right_enc, period_us,
                    input ready);
    modport sink   (input valid, frame_valid, left_enc, right_enc, period_us,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wodo_out_if.sv -----
// Output channel of the odometry block: valid/ready plus one result beat.
// No dependencies.
`default_nettype none

interface wodo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] left_position;
    logic signed [47:0] right_position;
    logic signed [31:0] left_velocity;
    logic signed [31:0] right_velocity;
    logic               updated;

    modport source (output valid, left_position, right_position, left_velocity,
                    right_velocity, updated, input ready);
    modport sink   (input valid, left_position, right_position, left_velocity,
                    right_velocity, updated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wodo_div.sv -----
// Restoring divider, one quotient bit per cycle: 68-bit numerator by 21-bit divisor.
// Gives a 32-bit quotient and an overflow flag when the quotient needs more bits.
`default_nettype none

module wodo_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [67:0] numer,
    input  wire logic [20:0] denom,
    output logic             done,
    output logic [31:0]      quot,
    output logic             ovf
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [20:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [20:0] den_reg, den_next;
    logic        ovf_reg, ovf_next;
    logic [21:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            // quotient of 2^32 or more: upper numerator already reaches the divisor
            ovf_next  = numer[67:32] >= {15'd0, denom};
            rem_next  = numer[52:32];
            quo_next  = numer[31:0];
            den_next  = denom;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 21'(trial - {1'b0, den_reg}) : trial[20:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wodo_lane.sv -----
// One wheel lane: tick bookkeeping, position scaling, windowed speed and EMA.
// Uses wodo_pkg types and instantiates wodo_div.
`default_nettype none

module wodo_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wodo_pkg::lane_cmd_t cmd,
    input  wire logic [31:0]        ticks,
    input  wire logic [20:0]        elapsed,
    input  wire wodo_pkg::cfg_t     cfg,
    output logic signed [47:0]      position,
    output logic signed [31:0]      velocity,
    output logic                    done
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_POS_LO   = 4'd1;
    localparam logic [3:0] ST_POS_HI   = 4'd2;
    localparam logic [3:0] ST_POS_SUM  = 4'd3;
    localparam logic [3:0] ST_POS_RND  = 4'd4;
    localparam logic [3:0] ST_SMUL     = 4'd5;
    localparam logic [3:0] ST_SN_LO    = 4'd6;
    localparam logic [3:0] ST_SN_HI    = 4'd7;
    localparam logic [3:0] ST_SN_SUM   = 4'd8;
    localparam logic [3:0] ST_DIV_GO   = 4'd9;
    localparam logic [3:0] ST_DIV_WAIT = 4'd10;
    localparam logic [3:0] ST_EMUL     = 4'd11;
    localparam logic [3:0] ST_EADD     = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    // control and wheel state
    logic [3:0]  state_reg, state_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] wstart_reg, wstart_next;
    logic [47:0] total_reg, total_next;
    logic [31:0] speed_reg, speed_next;

    // datapath
    logic               sample_en_reg, sample_en_next;
    logic               dneg_reg, dneg_next;
    logic [31:0]        dmag_reg, dmag_next;
    logic [20:0]        elapsed_reg, elapsed_next;
    logic [63:0]        prod_reg, prod_next;
    logic [31:0]        nhi_reg, nhi_next;
    logic [83:0]        acc_reg, acc_next;
    logic [47:0]        position_reg, position_next;
    logic [31:0]        sample_reg, sample_next;
    logic signed [50:0] ema_prod_reg, ema_prod_next;

    logic [31:0]        delta;
    logic [31:0]        dwin;
    logic               pneg;
    logic [47:0]        pmag;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [79:0]        rnd_sum;
    logic [63:0]        pv;
    logic               pover;
    logic [16:0]        alpha_eff;
    logic signed [32:0] diff;
    logic [34:0]        nv;

    logic               div_done;
    logic [31:0]        div_quot;
    logic               div_ovf;

    wodo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIV_GO),
        .numer (acc_reg[83:16]),
        .denom (elapsed_reg),
        .done  (div_done),
        .quot  (div_quot),
        .ovf   (div_ovf)
    );

    assign delta = ticks - last_reg;
    assign dwin  = ticks - wstart_reg;
    assign pneg  = total_reg[47];
    assign pmag  = pneg ? (48'd0 - total_reg) : total_reg;

    // one shared 32x32 multiplier per lane
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_POS_LO:
            begin
                mul_a = {8'd0, pmag[23:0]};
                mul_b = cfg.rad_per_tick;
            end
            ST_POS_HI:
            begin
                mul_a = {8'd0, pmag[47:24]};
                mul_b = cfg.rad_per_tick;
            end
            ST_SMUL:
            begin
                mul_a = dmag_reg;
                mul_b = cfg.rad_per_tick;
            end
            ST_SN_LO:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {12'd0, wodo_pkg::US_PER_SEC};
            end
            ST_SN_HI:
            begin
                mul_a = nhi_reg;
                mul_b = {12'd0, wodo_pkg::US_PER_SEC};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // position rounding: floor of the signed product, via ceil of the magnitude
    assign rnd_sum = acc_reg[79:0] + {64'd0, (pneg ? 16'hFFFF : 16'h0000)};
    assign pv      = rnd_sum[79:16];
    assign pover   = pneg ? ((pv[63:48] != 16'd0) || (pv[47] && (pv[46:0] != 47'd0)))
                          : (pv[63:47] != 17'd0);

    assign alpha_eff = cfg.ema_alpha[16] ? wodo_pkg::ALPHA_ONE : cfg.ema_alpha;
    assign diff      = $signed({sample_reg[31], sample_reg}) - $signed({speed_reg[31], speed_reg});
    assign nv        = {{3{speed_reg[31]}}, speed_reg} + ema_prod_reg[50:16];

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        wstart_next    = wstart_reg;
        total_next     = total_reg;
        speed_next     = speed_reg;
        sample_en_next = sample_en_reg;
        dneg_next      = dneg_reg;
        dmag_next      = dmag_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        nhi_next       = nhi_reg;
        acc_next       = acc_reg;
        position_next  = position_reg;
        sample_next    = sample_reg;
        ema_prod_next  = ema_prod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.seed)
                    begin
                        last_next   = ticks;
                        wstart_next = ticks;
                    end
                    if (cmd.advance)
                    begin
                        total_next = total_reg + {{16{delta[31]}}, delta};
                        last_next  = ticks;
                    end
                    if (cmd.sample)
                    begin
                        wstart_next = ticks;
                    end
                    sample_en_next = cmd.sample;
                    dneg_next      = dwin[31];
                    dmag_next      = dwin[31] ? (32'd0 - dwin) : dwin;
                    elapsed_next   = elapsed;
                    state_next     = ST_POS_LO;
                end
            end
            ST_POS_LO:
            begin
                prod_next  = mul_p;
                state_next = ST_POS_HI;
            end
            ST_POS_HI:
            begin
                acc_next   = {28'd0, prod_reg[55:0]};
                prod_next  = mul_p;
                state_next = ST_POS_SUM;
            end
            ST_POS_SUM:
            begin
                acc_next   = acc_reg + {4'd0, prod_reg[55:0], 24'd0};
                state_next = ST_POS_RND;
            end
            ST_POS_RND:
            begin
                if (pneg)
                    position_next = pover ? 48'h8000_0000_0000 : (48'd0 - pv[47:0]);
                else
                    position_next = pover ? 48'h7FFF_FFFF_FFFF : pv[47:0];
                state_next = sample_en_reg ? ST_SMUL : ST_DONE;
            end
            ST_SMUL:
            begin
                prod_next  = mul_p;
                state_next = ST_SN_LO;
            end
            ST_SN_LO:
            begin
                nhi_next   = prod_reg[63:32];
                prod_next  = mul_p;
                state_next = ST_SN_HI;
            end
            ST_SN_HI:
            begin
                acc_next   = {32'd0, prod_reg[51:0]};
                prod_next  = mul_p;
                state_next = ST_SN_SUM;
            end
            ST_SN_SUM:
            begin
                acc_next   = acc_reg + {prod_reg[51:0], 32'd0};
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (dneg_reg)
                        sample_next = (div_ovf || (div_quot[31] && (div_quot[30:0] != 31'd0)))
                                      ? 32'h8000_0000 : (32'd0 - div_quot);
                    else
                        sample_next = (div_ovf || div_quot[31]) ? 32'h7FFF_FFFF : div_quot;
                    state_next = ST_EMUL;
                end
            end
            ST_EMUL:
            begin
                ema_prod_next = $signed({1'b0, alpha_eff}) * diff;
                state_next    = ST_EADD;
            end
            ST_EADD:
            begin
                if ((nv[34:31] == 4'b0000) || (nv[34:31] == 4'b1111))
                    speed_next = nv[31:0];
                else
                    speed_next = nv[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= 32'd0;
            wstart_reg <= 32'd0;
            total_reg  <= 48'd0;
            speed_reg  <= 32'd0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            wstart_reg <= wstart_next;
            total_reg  <= total_next;
            speed_reg  <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_en_reg <= sample_en_next;
        dneg_reg      <= dneg_next;
        dmag_reg      <= dmag_next;
        elapsed_reg   <= elapsed_next;
        prod_reg      <= prod_next;
        nhi_reg       <= nhi_next;
        acc_reg       <= acc_next;
        position_reg  <= position_next;
        sample_reg    <= sample_next;
        ema_prod_reg  <= ema_prod_next;
    end

    assign position = position_reg;
    assign velocity = speed_reg;
    assign done     = (state_reg == ST_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/wheel_encoder_odometry_unit.sv -----
// Top level of the wheel encoder odometry block: APB registers, item sequencer,
// two wodo_lane instances and the result register. Uses wodo_pkg, wodo_in_if, wodo_out_if.
`default_nettype none

// Wheel odometry from cumulative quadrature counts. Each input beat carries
// the left and right encoder counts and the microseconds since the previous
// beat; each beat produces exactly one result beat with both wheel angles
// (signed Q31.16 rad) and both filtered speeds (signed Q15.16 rad/s). A beat
// with frame_valid low changes nothing and reports the current values; the
// first valid beat after reset only seeds the stored counts. Later valid beats
// add the wrapped count deltas to 48-bit tick totals and set updated. When the
// summed period reaches window_us, each wheel gets a speed sample
// (window ticks * rad_per_tick * 1e6 / elapsed) blended in with weight ema_alpha.
// One beat at a time: no new beat is taken until the last one has reached the
// result register. A beat that closes no speed window is paced by the position
// multiply, done as two 24x32 partial products in each lane; one that closes
// a window is paced by the 32-step restoring divider in each lane. The two lanes run in
// lock step and the result register lets a new beat in while the last
// result waits on out_ch.ready. Registers (APB, 32-bit data, byte address
// 4*index): rad_per_tick at 0x0, window_us at 0x4, ema_alpha at 0x8; write
// them only while the block is idle. window_us of 0 acts as 1 and ema_alpha
// above 65536 acts as 65536.

module wheel_encoder_odometry_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    wodo_in_if.sink                                in_ch,
    wodo_out_if.source                             out_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wodo_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    wodo_pkg::cfg_t      cfg_reg, cfg_next;
    wodo_pkg::lane_cmd_t cmd;

    logic [1:0]  state_reg, state_next;
    logic        seeded_reg, seeded_next;
    logic [20:0] welap_reg, welap_next;
    logic        upd_pend_reg, upd_pend_next;
    logic        done_l_reg, done_l_next;
    logic        done_r_reg, done_r_next;
    logic        out_valid_reg, out_valid_next;

    logic signed [47:0] out_lpos_reg, out_lpos_next;
    logic signed [47:0] out_rpos_reg, out_rpos_next;
    logic signed [31:0] out_lvel_reg, out_lvel_next;
    logic signed [31:0] out_rvel_reg, out_rvel_next;
    logic               out_upd_reg, out_upd_next;

    logic        accept;
    logic        cfg_wr;
    logic [19:0] win;
    logic [20:0] el_sum;
    logic        load_out;

    logic signed [47:0] l_pos, r_pos;
    logic signed [31:0] l_vel, r_vel;
    logic               l_done, r_done;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                wodo_pkg::REG_RAD_PER_TICK: cfg_next.rad_per_tick = pwdata;
                wodo_pkg::REG_WINDOW_US:    cfg_next.window_us    = pwdata[19:0];
                wodo_pkg::REG_EMA_ALPHA:    cfg_next.ema_alpha    = pwdata[16:0];
                default:                    cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            wodo_pkg::REG_RAD_PER_TICK: prdata = cfg_reg.rad_per_tick;
            wodo_pkg::REG_WINDOW_US:    prdata = {12'd0, cfg_reg.window_us};
            wodo_pkg::REG_EMA_ALPHA:    prdata = {15'd0, cfg_reg.ema_alpha};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- beat sequencer ----------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // zero window behaves as one microsecond
    assign win    = (cfg_reg.window_us == 20'd0) ? 20'd1 : cfg_reg.window_us;
    assign el_sum = welap_reg + {1'b0, in_ch.period_us};

    // lanes are launched straight from the accepted beat
    always_comb
    begin
        cmd.start   = accept;
        cmd.seed    = in_ch.frame_valid && !seeded_reg;
        cmd.advance = in_ch.frame_valid && seeded_reg;
        cmd.sample  = in_ch.frame_valid && seeded_reg && (el_sum >= {1'b0, win});
    end

    wodo_lane u_lane_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ticks    (in_ch.left_enc),
        .elapsed  (el_sum),
        .cfg      (cfg_reg),
        .position (l_pos),
        .velocity (l_vel),
        .done     (l_done)
    );

    wodo_lane u_lane_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ticks    (in_ch.right_enc),
        .elapsed  (el_sum),
        .cfg      (cfg_reg),
        .position (r_pos),
        .velocity (r_vel),
        .done     (r_done)
    );

    // merge: result register takes both lanes once the output slot is free
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        welap_next     = welap_reg;
        upd_pend_next  = upd_pend_reg;
        done_l_next    = done_l_reg;
        done_r_next    = done_r_reg;
        out_valid_next = out_valid_reg;
        out_lpos_next  = out_lpos_reg;
        out_rpos_next  = out_rpos_reg;
        out_lvel_next  = out_lvel_reg;
        out_rvel_next  = out_rvel_reg;
        out_upd_next   = out_upd_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.seed)
                    begin
                        seeded_next = 1'b1;
                        welap_next  = 21'd0;
                    end
                    else if (cmd.advance)
                    begin
                        welap_next = cmd.sample ? 21'd0 : el_sum;
                    end
                    upd_pend_next = cmd.advance;
                    done_l_next   = 1'b0;
                    done_r_next   = 1'b0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                done_l_next = done_l_reg || l_done;
                done_r_next = done_r_reg || r_done;
                if ((done_l_reg || l_done) && (done_r_reg || r_done))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_lpos_next  = l_pos;
                    out_rpos_next  = r_pos;
                    out_lvel_next  = l_vel;
                    out_rvel_next  = r_vel;
                    out_upd_next   = upd_pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rad_per_tick <= wodo_pkg::RAD_PER_TICK_RST;
            cfg_reg.window_us    <= wodo_pkg::WINDOW_US_RST;
            cfg_reg.ema_alpha    <= wodo_pkg::EMA_ALPHA_RST;
            state_reg            <= ST_IDLE;
            seeded_reg           <= 1'b0;
            welap_reg            <= 21'd0;
            upd_pend_reg         <= 1'b0;
            done_l_reg           <= 1'b0;
            done_r_reg           <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            welap_reg     <= welap_next;
            upd_pend_reg  <= upd_pend_next;
            done_l_reg    <= done_l_next;
            done_r_reg    <= done_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_lpos_reg <= out_lpos_next;
        out_rpos_reg <= out_rpos_next;
        out_lvel_reg <= out_lvel_next;
        out_rvel_reg <= out_rvel_next;
        out_upd_reg  <= out_upd_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.left_position  = out_lpos_reg;
    assign out_ch.right_position = out_rpos_reg;
    assign out_ch.left_velocity  = out_lvel_reg;
    assign out_ch.right_velocity = out_rvel_reg;
    assign out_ch.updated        = out_upd_reg;

endmodule

`default_nettype wire

// ----- tb/wodo_odometry_checker.sv -----
// Scoreboard for the wheel encoder odometry block: snoops APB writes and both beat
// channels, predicts each result beat and compares it field by field.
// Depends on wodo_pkg, wodo_in_if and wodo_out_if.

module wodo_odometry_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    wodo_in_if               in_ch,
    wodo_out_if              out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic signed [47:0] left_position;
        logic signed [47:0] right_position;
        logic signed [31:0] left_velocity;
        logic signed [31:0] right_velocity;
        logic               updated;
    } odometry_t;

    localparam logic signed [81:0] ANGLE_MAX = 82'sh7FFF_FFFF_FFFF;
    localparam logic signed [81:0] ANGLE_MIN = -82'sh8000_0000_0000;

    // register shadow
    logic [31:0] rad_q;
    logic [19:0] window_q;
    logic [16:0] alpha_q;

    // wheel state
    logic               seeded;
    logic [31:0]        l_last, r_last, l_win_start, r_win_start;
    logic [20:0]        win_elapsed;
    logic [47:0]        l_total, r_total;
    logic signed [31:0] l_speed, r_speed;

    odometry_t odometry_due_q[$];
    int        fail_cnt = 0;

    // floor(total * rad / 2^16), clamped to 48 bits
    function automatic logic signed [47:0] angle_of(logic [47:0] total);
        logic signed [81:0] prod;
        logic signed [81:0] shifted;
        prod    = $signed(total) * $signed({1'b0, rad_q});
        shifted = prod >>> 16;
        if (shifted > ANGLE_MAX)
            return ANGLE_MAX[47:0];
        if (shifted < ANGLE_MIN)
            return ANGLE_MIN[47:0];
        return shifted[47:0];
    endfunction

    // |ticks| * rad * 1e6 / (elapsed * 2^16), truncated, sign restored, clamped
    function automatic logic signed [31:0] speed_sample(logic [31:0] dticks,
                                                        logic [20:0] elapsed);
        logic        neg;
        logic [31:0] mag;
        logic [95:0] num;
        logic [95:0] quo;
        neg = dticks[31];
        mag = neg ? (32'd0 - dticks) : dticks;
        num = {64'd0, mag} * {64'd0, rad_q} * {76'd0, wodo_pkg::US_PER_SEC};
        quo = num / {59'd0, elapsed, 16'd0};
        if (!neg)
            return (quo > 96'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
        return (quo > 96'h8000_0000) ? 32'sh8000_0000 : (32'd0 - quo[31:0]);
    endfunction

    function automatic logic signed [31:0] ema_step(logic signed [31:0] old,
                                                    logic signed [31:0] sample);
        longint a;
        longint nv;
        a  = (alpha_q > wodo_pkg::ALPHA_ONE) ? longint'(wodo_pkg::ALPHA_ONE)
                                             : longint'(alpha_q);
        nv = longint'(old) + ((a * (longint'(sample) - longint'(old))) >>> 16);
        if (nv > 64'sd2147483647)
            nv = 64'sd2147483647;
        if (nv < -64'sd2147483648)
            nv = -64'sd2147483648;
        return nv[31:0];
    endfunction

    task automatic reset_odometry();
        rad_q       = wodo_pkg::RAD_PER_TICK_RST;
        window_q    = wodo_pkg::WINDOW_US_RST;
        alpha_q     = wodo_pkg::EMA_ALPHA_RST;
        seeded      = 1'b0;
        l_last      = '0;
        r_last      = '0;
        l_win_start = '0;
        r_win_start = '0;
        win_elapsed = '0;
        l_total     = '0;
        r_total     = '0;
        l_speed     = '0;
        r_speed     = '0;
        odometry_due_q.delete();
    endtask

    task automatic predict_odometry(input logic fv, input logic [31:0] lt,
                                    input logic [31:0] rt, input logic [19:0] per);
        logic [20:0] win;
        logic [31:0] dl;
        logic [31:0] dr;
        odometry_t   res;
        win         = (window_q == '0) ? 21'd1 : {1'b0, window_q};
        res.updated = 1'b0;
        if (fv && !seeded) begin
            l_last      = lt;
            r_last      = rt;
            l_win_start = lt;
            r_win_start = rt;
            win_elapsed = '0;
            seeded      = 1'b1;
        end
        else if (fv) begin
            dl          = lt - l_last;
            dr          = rt - r_last;
            l_total     = l_total + {{16{dl[31]}}, dl};
            r_total     = r_total + {{16{dr[31]}}, dr};
            l_last      = lt;
            r_last      = rt;
            win_elapsed = win_elapsed + {1'b0, per};
            if (win_elapsed >= win) begin
                l_speed     = ema_step(l_speed, speed_sample(lt - l_win_start, win_elapsed));
                r_speed     = ema_step(r_speed, speed_sample(rt - r_win_start, win_elapsed));
                l_win_start = lt;
                r_win_start = rt;
                win_elapsed = '0;
            end
            res.updated = 1'b1;
        end
        res.left_position  = angle_of(l_total);
        res.right_position = angle_of(r_total);
        res.left_velocity  = l_speed;
        res.right_velocity = r_speed;
        odometry_due_q.insert(odometry_due_q.size(), res);
    endtask

    task automatic compare_odometry();
        odometry_t exp_beat;
        if (odometry_due_q.size() == 0) begin
            $error("result beat arrived with no prediction pending");
            fail_cnt++;
            return;
        end
        exp_beat = odometry_due_q.pop_front();
        if (out_ch.left_position !== exp_beat.left_position) begin
            $error("left_position: expected %0d, actual %0d",
                   exp_beat.left_position, out_ch.left_position);
            fail_cnt++;
        end
        if (out_ch.right_position !== exp_beat.right_position) begin
            $error("right_position: expected %0d, actual %0d",
                   exp_beat.right_position, out_ch.right_position);
            fail_cnt++;
        end
        if (out_ch.left_velocity !== exp_beat.left_velocity) begin
            $error("left_velocity: expected %0d, actual %0d",
                   exp_beat.left_velocity, out_ch.left_velocity);
            fail_cnt++;
        end
        if (out_ch.right_velocity !== exp_beat.right_velocity) begin
            $error("right_velocity: expected %0d, actual %0d",
                   exp_beat.right_velocity, out_ch.right_velocity);
            fail_cnt++;
        end
        if (out_ch.updated !== exp_beat.updated) begin
            $error("updated: expected %0d, actual %0d", exp_beat.updated, out_ch.updated);
            fail_cnt++;
        end
    endtask

    // results leave before the beat accepted on the same edge is predicted
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            reset_odometry();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready)
                compare_odometry();
            if (in_ch.valid && in_ch.ready)
                predict_odometry(in_ch.frame_valid, in_ch.left_enc, in_ch.right_enc,
                                 in_ch.period_us);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    wodo_pkg::REG_RAD_PER_TICK: rad_q    = pwdata;
                    wodo_pkg::REG_WINDOW_US:    window_q = pwdata[19:0];
                    wodo_pkg::REG_EMA_ALPHA:    alpha_q  = pwdata[16:0];
                    default: ;
                endcase
            end
            outstanding <= odometry_due_q.size();
            mismatches  <= fail_cnt;
        end
    end

endmodule

// ----- tb/tb_wheel_encoder_odometry_unit.sv -----
// Testbench top for wheel_encoder_odometry_unit: clock, reset, APB setup and
// encoder beat stimulus; checking is done by wodo_odometry_checker.
// Depends on wodo_pkg, wodo_in_if, wodo_out_if and the checker.

module tb_wheel_encoder_odometry_unit;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wodo_in_if  in_bus();
    wodo_out_if out_bus();

    // idle rates in percent, changed per phase
    int src_idle_pct;
    int dst_idle_pct;

    int mismatches;
    int outstanding;
    int beats_sent   = 0;
    int no_frame_cnt = 0;
    int settings_cnt = 1;     // reset values count as the first setting

    // running encoder counts, so valid frames describe real wheel motion
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [19:0] cur_window;

    wheel_encoder_odometry_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wodo_odometry_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_bus),
        .out_ch      (out_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop, in case the run never reaches its end.
    initial
    begin
        #8000000;
        $display("wheel_encoder_odometry_unit test failed");
        $finish;
    end

    // Result side: one NBA per edge, ready drops at the current idle rate.
    always @(posedge clk)
    begin
        out_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // One input beat. Valid is only lowered inside an idle gap, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    task automatic send_beat(input logic fv, input logic [31:0] lt,
                             input logic [31:0] rt, input logic [19:0] per);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.frame_valid <= fv;
        in_bus.left_enc    <= lt;
        in_bus.right_enc   <= rt;
        in_bus.period_us   <= per;
        do @(posedge clk); while (in_bus.ready !== 1'b1);
        beats_sent++;
        if (!fv)
            no_frame_cnt++;
    endtask

    // valid frame that moves both wheels by the given (wrapping) deltas
    task automatic move_beat(input logic [31:0] dl, input logic [31:0] dr,
                             input logic [19:0] per);
        left_count  = left_count + dl;
        right_count = right_count + dr;
        send_beat(1'b1, left_count, right_count, per);
    endtask

    // Hold the sender off until every predicted result has come back.
    task automatic quiesce();
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phase; the caller closes the transfer after the last write.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
    endtask

    // Registers change only with the block drained.
    task automatic set_config(input logic [31:0] rpt, input logic [19:0] win,
                              input logic [16:0] alpha);
        quiesce();
        apb_write(wodo_pkg::REG_RAD_PER_TICK, rpt);
        apb_write(wodo_pkg::REG_WINDOW_US, {12'd0, win});
        apb_write(wodo_pkg::REG_EMA_ALPHA, {15'd0, alpha});
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        cur_window = win;
        settings_cnt++;
    endtask

    // Mostly small wheel motion; sometimes standstill, arbitrary jumps, or the
    // largest forward and backward steps a 32-bit count can express.
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom();
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(4000)) - 32'd2000;
        endcase
    endfunction

    // Mostly fractions of the window so samples take a few beats; the rest
    // covers zero, maximum and arbitrary periods.
    function automatic logic [19:0] pick_period();
        case ($urandom_range(9))
            0: return 20'd0;
            1: return 20'd1000000;
            2: return 20'($urandom_range(1000000));
            default: return 20'($urandom_range(cur_window / 2 + 1));
        endcase
    endfunction

    task automatic random_beats(input int count);
        logic fv;
        repeat (count)
        begin
            fv = ($urandom_range(99) >= 8);
            if (fv)
                move_beat(pick_delta(), pick_delta(), pick_period());
            else
                // no-frame beat: contents are junk and must be ignored
                send_beat(1'b0, $urandom(), $urandom(), pick_period());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_bus.valid       <= 1'b0;
        in_bus.frame_valid <= 1'b0;
        in_bus.left_enc    <= '0;
        in_bus.right_enc   <= '0;
        in_bus.period_us   <= '0;
        src_idle_pct       = 15;
        dst_idle_pct       = 77;
        left_count         = '0;
        right_count        = '0;
        cur_window         = wodo_pkg::WINDOW_US_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part, reset register values ----
        // beats before any frame: nothing moves, junk ticks and period ignored
        send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 20'd1000000);
        send_beat(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 20'd0);
        // first frame only seeds counts; its period does not count
        left_count  = 32'h7FFF_FFF0;
        right_count = 32'h8000_0010;
        send_beat(1'b1, left_count, right_count, 20'd1000000);
        // counts wrap across the sign boundary in both directions
        move_beat(32'd21, -32'd32, 20'd20000);
        // no frame in between: period must not reach the window
        send_beat(1'b0, 32'h1234_5678, 32'h0, 20'd1000000);
        // one microsecond short of the window, then exactly on it
        move_beat(32'd0, 32'd0, 20'd19999);
        move_beat(32'd1, -32'd1, 20'd1);
        // largest steps in one window: both samples clamp
        move_beat(32'h7FFF_FFFF, 32'h8000_0000, 20'd40000);
        move_beat(-32'd5, 32'd5, 20'd1000000);
        move_beat(32'd0, 32'd0, 20'd1000000);
        move_beat(32'd3, -32'd3, 20'd0);
        move_beat(32'hFFFF_FFFF, 32'd1, 20'd1);

        // ---- random part: six register settings over three idle regimes ----
        // sender idles lightly, receiver heavily
        set_config(32'd1, 20'd1, 17'd65536);                      // smallest rad and window
        random_beats(184);
        set_config(32'hFFFF_FFFF, 20'd1000000, 17'd1);            // positions clamp
        random_beats(184);

        // the other way round
        src_idle_pct = 77;
        dst_idle_pct = 15;
        set_config(32'd6588397, 20'd0, 17'h1FFFF);                // zero window, alpha over one
        random_beats(184);
        set_config($urandom(), 20'($urandom_range(100000, 1)),
                   17'($urandom_range(65536, 1)));
        random_beats(184);

        // full throughput both sides
        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_config(32'hFFFF_FFFF, 20'd20000, 17'd32768);
        random_beats(184);
        set_config(wodo_pkg::RAD_PER_TICK_RST, wodo_pkg::WINDOW_US_RST,
                   wodo_pkg::EMA_ALPHA_RST);
        random_beats(184);

        // drain, then give the block time to show any stray result
        quiesce();
        repeat (100) @(posedge clk);

        $display("Covered %0d beats (%0d without a frame) under %0d register settings,",
                 beats_sent, no_frame_cnt, settings_cnt);
        $display("including a zero window, alpha above one and clamped angles and speeds.");
        if (mismatches == 0 && outstanding == 0)
            $display("wheel_encoder_odometry_unit test passed");
        else
            $display("wheel_encoder_odometry_unit test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/wodo_pkg.sv
hw/rtl/wodo_in_if.sv
hw/rtl/wodo_out_if.sv
hw/rtl/wodo_div.sv
hw/rtl/wodo_lane.sv
hw/rtl/wheel_encoder_odometry_unit.sv
tb/wodo_odometry_checker.sv
tb/tb_wheel_encoder_odometry_unit.sv
